/* design/distance_joint_force_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the distance joint force block
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef DISTANCE_JOINT_FORCE_DEFINES_SVH
`define DISTANCE_JOINT_FORCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DJF_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define DJF_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define DJF_ASSERT(lbl, ck, rn, prop, msg)
`define DJF_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

/* design/djf_pkg.sv */
// ---------------------------------------------------------------------------
// Distance joint force package
// Shared widths, constants, register indexes, types and helper functions.
// ---------------------------------------------------------------------------
package djf_pkg;

  // Number of CORDIC iterations (8 to 24).
  localparam int CORDIC_STEPS = 16;

  // Rotator widths.
  localparam int ROT_IN_W   = 40;
  localparam int ROT_PROD_W = ROT_IN_W + 26;
  localparam int ROT_W      = ROT_PROD_W - 8;
  localparam int ROT_OUT_W  = ROT_W - 16;
  localparam int ZW         = 34;

  // Vectorer widths.
  localparam int VEC_IN_W = 34;
  localparam int VEC_W    = 48;
  localparam int LP_W     = 68;
  localparam int LEN_W    = LP_W - 28;

  // Force coefficient widths.
  localparam int DIFF_W = 42;
  localparam int PROD_W = 60;

  // Latency of one rotator or vectorer.
  localparam int L_CORDIC = CORDIC_STEPS + 2;

  localparam logic signed [ROT_PROD_W-1:0] GAIN_Q24 = ROT_PROD_W'(10188014);
  localparam logic [LP_W-1:0]              GAIN_Q20 = LP_W'(636751);

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_REST   = 3'd0;
  localparam logic [2:0] REG_RIGID  = 3'd1;
  localparam logic [2:0] REG_GROOVE = 3'd2;
  localparam logic [2:0] REG_PRES   = 3'd3;
  localparam logic [2:0] REG_AAX    = 3'd4;
  localparam logic [2:0] REG_AAY    = 3'd5;
  localparam logic [2:0] REG_ABX    = 3'd6;
  localparam logic [2:0] REG_ABY    = 3'd7;

  typedef struct packed {
    logic [30:0]        rest;
    logic [16:0]        rigidity;
    logic               groove;
    logic [1:0]         presence;
    logic signed [31:0] anchor_a_x;
    logic signed [31:0] anchor_a_y;
    logic signed [31:0] anchor_b_x;
    logic signed [31:0] anchor_b_y;
  } cfg_t;

  // A classified input transaction.
  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic [15:0]        angle_a;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic [15:0]        angle_b;
    logic               has_a;
    logic               has_b;
    logic               mov_a;
    logic               mov_b;
    logic               ksh17;
    logic               apply;
  } item_t;

  // Side information carried beside the gap measurement and force rotation.
  typedef struct packed {
    logic signed [31:0] off_a_x;
    logic signed [31:0] off_a_y;
    logic signed [31:0] off_b_x;
    logic signed [31:0] off_b_y;
    logic               mov_a;
    logic               mov_b;
    logic               ksh17;
    logic               apply;
    logic               nz;
  } mid_t;

  // Arctangent table, 32-bit binary angles.
  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Saturate a rotator result to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [ROT_OUT_W-1:0] v);
    logic signed [31:0] r;
    if (v > ROT_OUT_W'(64'sd2147483647)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -ROT_OUT_W'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/djf_queue.sv */
// ---------------------------------------------------------------------------
// Transaction queue
// Two-entry queue between the front and back parts.
// ---------------------------------------------------------------------------
`include "distance_joint_force_defines.svh"
module djf_queue import djf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output item_t item_out,
  output logic  empty
);

  item_t      mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item_in;
    end
  end

  assign item_out = mem_r[rp_r];
  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;

  `DJF_NEVER(a_no_overflow, clk, rst_n, push && full, "push into a full queue")
  `DJF_NEVER(a_no_underflow, clk, rst_n, pop && empty, "pop from an empty queue")
  `DJF_ASSERT(a_drains, clk, rst_n, !empty |-> pop, "back part left a transaction waiting")
  `DJF_ASSERT(a_push_seen, clk, rst_n, push && !pop |=> !empty, "pushed transaction lost")

endmodule

/* design/djf_front.sv */
// ---------------------------------------------------------------------------
// Front part
// Accepts input transactions and classifies the bodies of each joint.
// ---------------------------------------------------------------------------
module djf_front import djf_pkg::*; (
  input  logic               start,
  input  logic               q_full,
  input  logic [1:0]         presence,
  input  logic signed [31:0] in_pos_a_x,
  input  logic signed [31:0] in_pos_a_y,
  input  logic [15:0]        in_angle_a,
  input  logic               in_static_a,
  input  logic signed [31:0] in_pos_b_x,
  input  logic signed [31:0] in_pos_b_y,
  input  logic [15:0]        in_angle_b,
  input  logic               in_static_b,
  output logic               push,
  output item_t              item
);

  // Movable bodies decide the force share and whether anything applies.
  always_comb begin
    item.pos_a_x = in_pos_a_x;
    item.pos_a_y = in_pos_a_y;
    item.angle_a = in_angle_a;
    item.pos_b_x = in_pos_b_x;
    item.pos_b_y = in_pos_b_y;
    item.angle_b = in_angle_b;
    item.has_a   = presence[0];
    item.has_b   = presence[1];
    item.mov_a   = presence[0] & ~in_static_a;
    item.mov_b   = presence[1] & ~in_static_b;
    item.ksh17   = item.mov_a & item.mov_b;
    item.apply   = item.mov_a | item.mov_b;
  end

  assign push = start & ~q_full;

endmodule

/* design/djf_rot.sv */
// ---------------------------------------------------------------------------
// Pipelined CORDIC rotator
// Rotates a vector counterclockwise by a 32-bit binary angle, one stage
// per iteration, with gain pre-scaling and rounding.
// ---------------------------------------------------------------------------
module djf_rot import djf_pkg::*; (
  input  logic                        clk,
  input  logic signed [ROT_IN_W-1:0]  vx_i,
  input  logic signed [ROT_IN_W-1:0]  vy_i,
  input  logic [31:0]                 ang_i,
  output logic signed [ROT_OUT_W-1:0] ox_o,
  output logic signed [ROT_OUT_W-1:0] oy_o
);

  logic signed [ROT_W-1:0]      x_r [CORDIC_STEPS+1];
  logic signed [ROT_W-1:0]      y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]         z_r [CORDIC_STEPS+1];
  logic                         fold;
  logic signed [ROT_IN_W-1:0]   fx, fy;
  logic [31:0]                  fang;
  logic signed [ROT_PROD_W-1:0] px, py;
  logic signed [ROT_W-1:0]      rx, ry;

  // Fold the second and third quadrants and pre-scale by the gain.
  always_comb begin
    fold = ang_i[31] ^ ang_i[30];
    fx   = fold ? -vx_i : vx_i;
    fy   = fold ? -vy_i : vy_i;
    fang = {ang_i[31] ^ fold, ang_i[30:0]};
    px   = ROT_PROD_W'(fx) * GAIN_Q24;
    py   = ROT_PROD_W'(fy) * GAIN_Q24;
  end

  always_ff @(posedge clk) begin
    x_r[0] <= px[ROT_PROD_W-1:8];
    y_r[0] <= py[ROT_PROD_W-1:8];
    z_r[0] <= ZW'($signed(fang));
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ZW'(atan_val(i));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ZW'(atan_val(i));
      end
    end
  end

  // Round half up to Q16.16.
  always_comb begin
    rx = x_r[CORDIC_STEPS] + ROT_W'(32768);
    ry = y_r[CORDIC_STEPS] + ROT_W'(32768);
  end

  always_ff @(posedge clk) begin
    ox_o <= rx[ROT_W-1:16];
    oy_o <= ry[ROT_W-1:16];
  end

endmodule

/* design/djf_vec.sv */
// ---------------------------------------------------------------------------
// Pipelined CORDIC vectorer
// Measures the length and direction of a gap vector, one stage per
// iteration, then removes the gain.
// ---------------------------------------------------------------------------
module djf_vec import djf_pkg::*; (
  input  logic                       clk,
  input  logic signed [VEC_IN_W-1:0] dx_i,
  input  logic signed [VEC_IN_W-1:0] dy_i,
  output logic [LEN_W-1:0]           len_o,
  output logic [31:0]                ang_o
);

  logic signed [VEC_W-1:0]  x_r [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0]  y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]     z_r [CORDIC_STEPS+1];
  logic                     base_r [CORDIC_STEPS+1];
  logic                     neg;
  logic signed [VEC_IN_W:0] ax, ay;
  logic [VEC_W-1:0]         xc;
  logic [LP_W-1:0]          lp;

  // Move the gap into the right half plane and add guard bits.
  always_comb begin
    neg = dx_i[VEC_IN_W-1];
    ax  = neg ? -(VEC_IN_W+1)'(dx_i) : (VEC_IN_W+1)'(dx_i);
    ay  = neg ? -(VEC_IN_W+1)'(dy_i) : (VEC_IN_W+1)'(dy_i);
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= VEC_W'(ax) <<< 8;
    y_r[0]    <= VEC_W'(ay) <<< 8;
    z_r[0]    <= '0;
    base_r[0] <= neg;
  end

  // One micro-rotation per stage, driving y toward zero.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      base_r[i+1] <= base_r[i];
      if (!y_r[i][VEC_W-1] && (y_r[i] != '0)) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ZW'(atan_val(i));
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ZW'(atan_val(i));
      end
    end
  end

  // Remove the gain with rounding and rebuild the full-turn direction.
  always_comb begin
    xc = x_r[CORDIC_STEPS][VEC_W-1] ? '0 : x_r[CORDIC_STEPS];
    lp = LP_W'(xc) * GAIN_Q20 + LP_W'(1 << 27);
  end

  always_ff @(posedge clk) begin
    len_o <= lp[LP_W-1:28];
    ang_o <= {base_r[CORDIC_STEPS], 31'd0} + z_r[CORDIC_STEPS][31:0];
  end

endmodule

/* design/djf_back.sv */
// ---------------------------------------------------------------------------
// Back part
// Rotates both anchors, measures the gap, forms the spring coefficient and
// rotates it onto the gap direction. Takes one transaction per cycle.
// ---------------------------------------------------------------------------
module djf_back import djf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               pop,
  output logic               out_valid,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic               out_apply_a,
  output logic               out_apply_b,
  output logic signed [31:0] out_offset_a_x,
  output logic signed [31:0] out_offset_a_y,
  output logic signed [31:0] out_offset_b_x,
  output logic signed [31:0] out_offset_b_y
);

  // Delay lines beside the CORDIC units.
  item_t                       d1_r [L_CORDIC];
  logic                        v1_r [L_CORDIC];
  mid_t                        d2_r [L_CORDIC];
  logic                        v2_r [L_CORDIC];
  mid_t                        d3_r [L_CORDIC];
  logic                        v3_r [L_CORDIC];

  logic signed [ROT_OUT_W-1:0] oax, oay, obx, oby, ofx, ofy;
  logic signed [31:0]          offax, offay, offbx, offby;
  logic signed [VEC_IN_W-1:0]  gax, gay, gbx, gby, dx, dy;

  logic signed [VEC_IN_W-1:0]  dx_r, dy_r;
  mid_t                        s1_r, s2_r, s3_r, s4_r;
  mid_t                        s2_nxt;
  logic                        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [LEN_W-1:0]            len;
  logic [31:0]                 dir;
  logic [31:0]                 dir2_r, dir3_r, dir4_r;
  logic signed [DIFF_W-1:0]    diff_r;
  logic signed [PROD_W-1:0]    prod_r, rnd, shf;
  logic signed [ROT_IN_W-1:0]  c_r;
  logic                        apply2;

  assign pop = ~q_empty;

  // Anchor rotation for both bodies.
  djf_rot u_rot_a (
    .clk   (clk),
    .vx_i  (ROT_IN_W'(cfg.anchor_a_x)),
    .vy_i  (ROT_IN_W'(cfg.anchor_a_y)),
    .ang_i ({q_item.angle_a, 16'd0}),
    .ox_o  (oax),
    .oy_o  (oay)
  );

  djf_rot u_rot_b (
    .clk   (clk),
    .vx_i  (ROT_IN_W'(cfg.anchor_b_x)),
    .vy_i  (ROT_IN_W'(cfg.anchor_b_y)),
    .ang_i ({q_item.angle_b, 16'd0}),
    .ox_o  (obx),
    .oy_o  (oby)
  );

  // Valid bits of all delay lines.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L_CORDIC; k++) begin
        v1_r[k] <= 1'b0;
        v2_r[k] <= 1'b0;
        v3_r[k] <= 1'b0;
      end
    end else begin
      v1_r[0] <= pop;
      v2_r[0] <= s1_v_r;
      v3_r[0] <= s4_v_r;
      for (int k = 1; k < L_CORDIC; k++) begin
        v1_r[k] <= v1_r[k-1];
        v2_r[k] <= v2_r[k-1];
        v3_r[k] <= v3_r[k-1];
      end
    end
  end

  // Payload of all delay lines.
  always_ff @(posedge clk) begin
    d1_r[0] <= q_item;
    d2_r[0] <= s1_r;
    d3_r[0] <= s4_r;
    for (int k = 1; k < L_CORDIC; k++) begin
      d1_r[k] <= d1_r[k-1];
      d2_r[k] <= d2_r[k-1];
      d3_r[k] <= d3_r[k-1];
    end
  end

  // World anchor points and their gap.
  always_comb begin
    offax = d1_r[L_CORDIC-1].has_a ? sat32(oax) : 32'sd0;
    offay = d1_r[L_CORDIC-1].has_a ? sat32(oay) : 32'sd0;
    offbx = d1_r[L_CORDIC-1].has_b ? sat32(obx) : 32'sd0;
    offby = d1_r[L_CORDIC-1].has_b ? sat32(oby) : 32'sd0;
    gax = d1_r[L_CORDIC-1].has_a ?
          VEC_IN_W'(d1_r[L_CORDIC-1].pos_a_x) + VEC_IN_W'(offax) :
          VEC_IN_W'(cfg.anchor_a_x);
    gay = d1_r[L_CORDIC-1].has_a ?
          VEC_IN_W'(d1_r[L_CORDIC-1].pos_a_y) + VEC_IN_W'(offay) :
          VEC_IN_W'(cfg.anchor_a_y);
    gbx = d1_r[L_CORDIC-1].has_b ?
          VEC_IN_W'(d1_r[L_CORDIC-1].pos_b_x) + VEC_IN_W'(offbx) :
          VEC_IN_W'(cfg.anchor_b_x);
    gby = d1_r[L_CORDIC-1].has_b ?
          VEC_IN_W'(d1_r[L_CORDIC-1].pos_b_y) + VEC_IN_W'(offby) :
          VEC_IN_W'(cfg.anchor_b_y);
    dx = gbx - gax;
    dy = gby - gay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= v1_r[L_CORDIC-1];
    end
  end

  always_ff @(posedge clk) begin
    dx_r          <= dx;
    dy_r          <= dy;
    s1_r.off_a_x  <= offax;
    s1_r.off_a_y  <= offay;
    s1_r.off_b_x  <= offbx;
    s1_r.off_b_y  <= offby;
    s1_r.mov_a    <= d1_r[L_CORDIC-1].mov_a;
    s1_r.mov_b    <= d1_r[L_CORDIC-1].mov_b;
    s1_r.ksh17    <= d1_r[L_CORDIC-1].ksh17;
    s1_r.apply    <= d1_r[L_CORDIC-1].apply;
    s1_r.nz       <= (dx != '0) || (dy != '0);
  end

  // Gap length and direction.
  djf_vec u_vec (
    .clk   (clk),
    .dx_i  (dx_r),
    .dy_i  (dy_r),
    .len_o (len),
    .ang_o (dir)
  );

  // Groove check and the length error.
  assign apply2 = d2_r[L_CORDIC-1].apply &
                  ~(cfg.groove & (len < LEN_W'(cfg.rest)));

  always_comb begin
    s2_nxt       = d2_r[L_CORDIC-1];
    s2_nxt.apply = apply2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= v2_r[L_CORDIC-1];
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r       <= s2_nxt;
    dir2_r     <= dir;
    diff_r     <= DIFF_W'(cfg.rest) - DIFF_W'(len);
  end

  // Scale by the stiffness.
  always_ff @(posedge clk) begin
    s3_r   <= s2_r;
    dir3_r <= dir2_r;
    prod_r <= PROD_W'(diff_r) * PROD_W'({1'b0, cfg.rigidity});
  end

  // Share between the bodies with rounding; skipped joints feed zero.
  always_comb begin
    rnd = prod_r + (s3_r.ksh17 ? PROD_W'(1 << 16) : PROD_W'(1 << 15));
    shf = s3_r.ksh17 ? (rnd >>> 17) : (rnd >>> 16);
  end

  always_ff @(posedge clk) begin
    s4_r   <= s3_r;
    dir4_r <= dir3_r;
    c_r    <= (s3_r.apply && s3_r.nz) ? shf[ROT_IN_W-1:0] : '0;
  end

  // Turn the coefficient onto the gap direction.
  djf_rot u_rot_f (
    .clk   (clk),
    .vx_i  (c_r),
    .vy_i  ('0),
    .ang_i (dir4_r),
    .ox_o  (ofx),
    .oy_o  (ofy)
  );

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3_r[L_CORDIC-1];
    end
  end

  always_ff @(posedge clk) begin
    out_force_x    <= sat32(ofx);
    out_force_y    <= sat32(ofy);
    out_apply_a    <= d3_r[L_CORDIC-1].apply & d3_r[L_CORDIC-1].mov_a;
    out_apply_b    <= d3_r[L_CORDIC-1].apply & d3_r[L_CORDIC-1].mov_b;
    out_offset_a_x <= d3_r[L_CORDIC-1].off_a_x;
    out_offset_a_y <= d3_r[L_CORDIC-1].off_a_y;
    out_offset_b_x <= d3_r[L_CORDIC-1].off_b_x;
    out_offset_b_y <= d3_r[L_CORDIC-1].off_b_y;
  end

endmodule

/* design/distance_joint_force.sv */
// ---------------------------------------------------------------------------
// Distance joint force
// Spring force of a distance joint between two bodies, Q16.16.
// ---------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  input     start / busy                in_pos_*, in_angle_*, in_static_*
//  result    out_valid (one-cycle pulse)  out_force_*, out_apply_*, out_offset_*
//  config    psel/penable/pwrite, pready  paddr, pwdata, prdata
//
//  One transaction is accepted per cycle while busy is low. Each result
//  passes through the two anchor rotators, the gap vectorer and the force
//  rotator, each CORDIC_STEPS+2 stages deep, and the registers between them.
//  Reset is synchronous and reaches the control and configuration registers only.
//  The result side cannot stall, so busy only rises if the queue fills.
// ---------------------------------------------------------------------------
module distance_joint_force import djf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_a_x,
  input  logic signed [31:0] in_pos_a_y,
  input  logic [15:0]        in_angle_a,
  input  logic               in_static_a,
  input  logic signed [31:0] in_pos_b_x,
  input  logic signed [31:0] in_pos_b_y,
  input  logic [15:0]        in_angle_b,
  input  logic               in_static_b,
  output logic               out_valid,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic               out_apply_a,
  output logic               out_apply_b,
  output logic signed [31:0] out_offset_a_x,
  output logic signed [31:0] out_offset_a_y,
  output logic signed [31:0] out_offset_b_x,
  output logic signed [31:0] out_offset_b_y
);

  cfg_t  cfg_r;
  logic  wr_en;
  logic  push, pop, q_full, q_empty;
  item_t f_item, q_item;

  // Configuration writes.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest       <= '0;
      cfg_r.rigidity   <= 17'd65536;
      cfg_r.groove     <= 1'b0;
      cfg_r.presence   <= 2'd3;
      cfg_r.anchor_a_x <= '0;
      cfg_r.anchor_a_y <= '0;
      cfg_r.anchor_b_x <= '0;
      cfg_r.anchor_b_y <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_REST:   cfg_r.rest       <= pwdata[30:0];
        REG_RIGID:  cfg_r.rigidity   <= pwdata[16:0];
        REG_GROOVE: cfg_r.groove     <= pwdata[0];
        REG_PRES:   cfg_r.presence   <= pwdata[1:0];
        REG_AAX:    cfg_r.anchor_a_x <= pwdata;
        REG_AAY:    cfg_r.anchor_a_y <= pwdata;
        REG_ABX:    cfg_r.anchor_b_x <= pwdata;
        REG_ABY:    cfg_r.anchor_b_y <= pwdata;
        default: ;
      endcase
    end
  end

  // Configuration reads.
  always_comb begin
    case (paddr[4:2])
      REG_REST:   prdata = {1'b0, cfg_r.rest};
      REG_RIGID:  prdata = {15'd0, cfg_r.rigidity};
      REG_GROOVE: prdata = {31'd0, cfg_r.groove};
      REG_PRES:   prdata = {30'd0, cfg_r.presence};
      REG_AAX:    prdata = cfg_r.anchor_a_x;
      REG_AAY:    prdata = cfg_r.anchor_a_y;
      REG_ABX:    prdata = cfg_r.anchor_b_x;
      REG_ABY:    prdata = cfg_r.anchor_b_y;
      default:    prdata = '0;
    endcase
  end

  // Front part: accept and classify.
  djf_front u_front (
    .start       (start),
    .q_full      (q_full),
    .presence    (cfg_r.presence),
    .in_pos_a_x  (in_pos_a_x),
    .in_pos_a_y  (in_pos_a_y),
    .in_angle_a  (in_angle_a),
    .in_static_a (in_static_a),
    .in_pos_b_x  (in_pos_b_x),
    .in_pos_b_y  (in_pos_b_y),
    .in_angle_b  (in_angle_b),
    .in_static_b (in_static_b),
    .push        (push),
    .item        (f_item)
  );

  assign busy = q_full;

  djf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (f_item),
    .full     (q_full),
    .pop      (pop),
    .item_out (q_item),
    .empty    (q_empty)
  );

  // Back part: the arithmetic pipeline.
  djf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_force_x    (out_force_x),
    .out_force_y    (out_force_y),
    .out_apply_a    (out_apply_a),
    .out_apply_b    (out_apply_b),
    .out_offset_a_x (out_offset_a_x),
    .out_offset_a_y (out_offset_a_y),
    .out_offset_b_x (out_offset_b_x),
    .out_offset_b_y (out_offset_b_y)
  );

endmodule
